### hdl/fdep_pkg.sv
`default_nettype none

package fdep_pkg;

  localparam int LongNameSlots = 15;
  localparam int StoreDepth    = 13 * LongNameSlots + 1;
  localparam int StoreAw       = $clog2(StoreDepth);
  localparam int StorePw       = $clog2(StoreDepth + 1);
  localparam int LfnAw         = 9;

  localparam logic [7:0] ByteDeleted = 8'hE5;
  localparam logic [7:0] AttrLongName = 8'h0F;
  localparam logic [7:0] SeqFirstFlag = 8'h40;
  localparam logic [7:0] LowerBase = 8'h08;
  localparam logic [7:0] LowerExt = 8'h10;
  localparam logic [7:0] AttrDirectory = 8'h10;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot = 8'h2E;
  localparam logic [3:0] LfnChars = 4'd13;

  localparam logic [4:0] CharOffsets [13] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  typedef struct packed {
    logic capture;
    logic decode;
    logic lfn_write;
    logic sfn_write;
    logic rd_issue;
    logic rd_take;
  } cmd_t;

  typedef struct packed {
    logic ended;
    logic is_eod;
    logic is_deleted;
    logic is_lfn;
    logic need_build;
    logic lfn_done;
    logic sfn_done;
    logic term;
    logic full;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] csum_step(input logic [7:0] sum, input logic [7:0] b);
    csum_step = {sum[0], sum[7:1]} + b;
  endfunction

  function automatic logic [7:0] lower_if(input logic [7:0] c, input logic on);
    if (on && c >= 8'h41 && c <= 8'h5A) begin
      lower_if = c + 8'h20;
    end else begin
      lower_if = c;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/fat_directory_entry_parser_top.sv
// Deleted entries end at decode; an end-of-directory entry ends at decode once the
// output register is free. A long-name entry makes one name store write per cycle.
// A short entry with no matching long name first writes its own name to the store, then
// reads it byte by byte from the registered-read name store, with at most 196 bytes read.
// One entry is worked on at a time; the last result waits in the output register
// while the next entry is taken. Reset clears control and run state, not the name store.
`default_nettype none

module fat_directory_entry_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] entry_bytes_a_i,
  input  wire logic [63:0] entry_bytes_b_i,
  input  wire logic [63:0] entry_bytes_c_i,
  input  wire logic [63:0] entry_bytes_d_i,
  input  wire logic        new_directory_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      name_chunk_o,
  output logic [3:0]       chunk_bytes_o,
  output logic             last_chunk_o,
  output logic             end_of_directory_o,
  output logic [7:0]       attributes_o,
  output logic [31:0]      file_size_o,
  output logic [31:0]      first_cluster_o,
  output logic [31:0]      created_stamp_o,
  output logic [31:0]      modified_stamp_o,
  output logic [15:0]      accessed_date_o,
  output logic [15:0]      entry_start_o,
  output logic [7:0]       entry_count_o
);

  fdep_pkg::cmd_t cmd;
  fdep_pkg::sts_t sts;

  fdep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdep_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .entry_bytes_a_i    (entry_bytes_a_i),
    .entry_bytes_b_i    (entry_bytes_b_i),
    .entry_bytes_c_i    (entry_bytes_c_i),
    .entry_bytes_d_i    (entry_bytes_d_i),
    .new_directory_i    (new_directory_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .name_chunk_o       (name_chunk_o),
    .chunk_bytes_o      (chunk_bytes_o),
    .last_chunk_o       (last_chunk_o),
    .end_of_directory_o (end_of_directory_o),
    .attributes_o       (attributes_o),
    .file_size_o        (file_size_o),
    .first_cluster_o    (first_cluster_o),
    .created_stamp_o    (created_stamp_o),
    .modified_stamp_o   (modified_stamp_o),
    .accessed_date_o    (accessed_date_o),
    .entry_start_o      (entry_start_o),
    .entry_count_o      (entry_count_o)
  );

  a_eod_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_directory_o |-> last_chunk_o && chunk_bytes_o == 4'd0)
    else $error("end-of-directory word is not a bare final word");

  a_full_chunk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_chunk_o |-> chunk_bytes_o == 4'd8)
    else $error("a word before the last one is not full");

  a_max_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chunk_bytes_o <= 4'd8)
    else $error("word carries more than eight bytes");

  a_one_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("entry taken while the previous one is being decoded");

endmodule

`default_nettype wire

### hdl/fdep_ram.sv
`default_nettype none

module fdep_ram #(
  parameter int Width = 8,
  parameter int Depth = 196
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/fdep_ctrl.sv
`default_nettype none

module fdep_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire fdep_pkg::sts_t sts_i,
  output fdep_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StLfnWr  = 3'd2;
  localparam logic [2:0] StSfnWr  = 3'd3;
  localparam logic [2:0] StRdReq  = 3'd4;
  localparam logic [2:0] StRdData = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.ended) begin
          state_d = StIdle;
        end else if (sts_i.is_eod) begin
          if (sts_i.out_free) begin
            cmd_o.decode = 1'b1;
            state_d = StIdle;
          end
        end else if (sts_i.is_deleted) begin
          cmd_o.decode = 1'b1;
          state_d = StIdle;
        end else if (sts_i.is_lfn) begin
          cmd_o.decode = 1'b1;
          state_d = StLfnWr;
        end else begin
          cmd_o.decode = 1'b1;
          state_d = sts_i.need_build ? StSfnWr : StRdReq;
        end
      end
      StLfnWr: begin
        cmd_o.lfn_write = 1'b1;
        if (sts_i.lfn_done) begin
          state_d = StIdle;
        end
      end
      StSfnWr: begin
        cmd_o.sfn_write = 1'b1;
        if (sts_i.sfn_done) begin
          state_d = StRdReq;
        end
      end
      StRdReq: begin
        cmd_o.rd_issue = 1'b1;
        state_d = StRdData;
      end
      StRdData: begin
        if (sts_i.out_free || (!sts_i.full && !sts_i.term)) begin
          cmd_o.rd_take = 1'b1;
          state_d = sts_i.term ? StIdle : StRdReq;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/fdep_dp.sv
`default_nettype none

module fdep_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [63:0]    entry_bytes_a_i,
  input  wire logic [63:0]    entry_bytes_b_i,
  input  wire logic [63:0]    entry_bytes_c_i,
  input  wire logic [63:0]    entry_bytes_d_i,
  input  wire logic           new_directory_i,
  input  wire fdep_pkg::cmd_t cmd_i,
  output fdep_pkg::sts_t      sts_o,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output logic [63:0]         name_chunk_o,
  output logic [3:0]          chunk_bytes_o,
  output logic                last_chunk_o,
  output logic                end_of_directory_o,
  output logic [7:0]          attributes_o,
  output logic [31:0]         file_size_o,
  output logic [31:0]         first_cluster_o,
  output logic [31:0]         created_stamp_o,
  output logic [31:0]         modified_stamp_o,
  output logic [15:0]         accessed_date_o,
  output logic [15:0]         entry_start_o,
  output logic [7:0]          entry_count_o
);

  logic [255:0] entry_q;
  logic [7:0]   b [32];
  logic [7:0]   csum_part_q;
  logic [15:0]  index_q;
  logic         seen_q;
  logic [7:0]   lcsum_q;
  logic [15:0]  rstart_q;
  logic [7:0]   rlen_q;
  logic         ended_q;
  logic [3:0]   wcnt_q;
  logic [3:0]   wpos_q;
  logic [fdep_pkg::StorePw-1:0] rp_q;
  logic [3:0]   n_q;
  logic [63:0]  chunk_q;
  logic         cap_q;
  logic         out_valid_q;

  logic [7:0]   csum_part;
  logic [7:0]   csum;
  logic [7:0]   rdata;
  logic [7:0]   rlen_inc;
  logic         first;
  logic [3:0]   seq;
  logic [3:0]   seqm1;
  logic         is_dir;
  logic         load_eod;
  logic         emit;
  logic         we;
  logic [fdep_pkg::LfnAw-1:0] waddr;
  logic [7:0]   wdata;
  logic [3:0]   lane;

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      b[k] = entry_q[8*k +: 8];
    end
  end

  always_comb begin
    csum_part = 8'd0;
    for (int k = 0; k < 6; k++) begin
      csum_part = fdep_pkg::csum_step(csum_part, entry_bytes_a_i[8*k +: 8]);
    end
    csum = csum_part_q;
    for (int k = 6; k < 11; k++) begin
      csum = fdep_pkg::csum_step(csum, b[k]);
    end
  end

  assign first    = (b[0] & fdep_pkg::SeqFirstFlag) != 8'd0;
  assign seq      = b[0][3:0];
  assign seqm1    = (seq == 4'd0) ? 4'd0 : seq - 4'd1;
  assign is_dir   = (b[11] & fdep_pkg::AttrDirectory) != 8'd0;
  assign rlen_inc = (rlen_q == 8'hFF) ? rlen_q : rlen_q + 8'd1;
  assign load_eod = cmd_i.decode && sts_o.is_eod && !ended_q;
  assign emit     = cmd_i.rd_take && (sts_o.full || sts_o.term);
  assign lane     = n_q;

  always_comb begin
    sts_o            = '0;
    sts_o.ended      = ended_q;
    sts_o.is_eod     = b[0] == 8'd0;
    sts_o.is_deleted = b[0] == fdep_pkg::ByteDeleted;
    sts_o.is_lfn     = b[11] == fdep_pkg::AttrLongName;
    sts_o.need_build = !seen_q || (csum != lcsum_q);
    sts_o.lfn_done   = wcnt_q == fdep_pkg::LfnChars;
    sts_o.sfn_done   = (wcnt_q == 4'd8 && is_dir) || wcnt_q == 4'd12;
    sts_o.term       = cap_q || rdata == 8'd0;
    sts_o.full       = n_q == 4'd8;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = 8'd0;
    if (cmd_i.lfn_write) begin
      we = 1'b1;
      if (wcnt_q == 4'd0) begin
        waddr = fdep_pkg::LfnAw'({5'd0, seq} * 9'd13);
      end else begin
        waddr = fdep_pkg::LfnAw'({5'd0, seqm1} * 9'd13) + {5'd0, wcnt_q - 4'd1};
        wdata = b[fdep_pkg::CharOffsets[wcnt_q - 4'd1]];
      end
    end else if (cmd_i.sfn_write) begin
      waddr = {5'd0, wpos_q};
      if (wcnt_q < 4'd8) begin
        we    = b[{1'b0, wcnt_q}] != fdep_pkg::CharSpace;
        wdata = fdep_pkg::lower_if(b[{1'b0, wcnt_q}], (b[12] & fdep_pkg::LowerBase) != 8'd0);
      end else if (wcnt_q == 4'd8) begin
        we    = 1'b1;
        wdata = is_dir ? 8'd0 : fdep_pkg::CharDot;
      end else if (wcnt_q < 4'd12) begin
        we    = 1'b1;
        wdata = fdep_pkg::lower_if(b[5'({1'b0, wcnt_q} - 5'd1)],
                                   (b[12] & fdep_pkg::LowerExt) != 8'd0);
      end else begin
        we = 1'b1;
      end
    end
  end

  fdep_ram #(
    .Width (8),
    .Depth (fdep_pkg::StoreDepth)
  ) u_name_store (
    .clk_i   (clk_i),
    .we_i    (we && waddr < fdep_pkg::LfnAw'(fdep_pkg::StoreDepth)),
    .waddr_i (waddr[fdep_pkg::StoreAw-1:0]),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue && rp_q < fdep_pkg::StorePw'(fdep_pkg::StoreDepth)),
    .raddr_i (rp_q[fdep_pkg::StoreAw-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= '0;
      seen_q      <= 1'b0;
      lcsum_q     <= '0;
      rstart_q    <= '0;
      rlen_q      <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture && new_directory_i) begin
        index_q  <= '0;
        seen_q   <= 1'b0;
        lcsum_q  <= '0;
        rstart_q <= '0;
        rlen_q   <= '0;
        ended_q  <= 1'b0;
      end
      if (cmd_i.decode && !ended_q) begin
        if (sts_o.is_eod) begin
          ended_q <= 1'b1;
        end else if (sts_o.is_deleted) begin
          index_q <= index_q + 16'd1;
        end else if (sts_o.is_lfn) begin
          lcsum_q <= b[13];
          seen_q  <= 1'b1;
          if (first) begin
            rstart_q <= index_q;
            rlen_q   <= 8'd1;
          end else begin
            rlen_q <= rlen_inc;
          end
          index_q <= index_q + 16'd1;
        end else begin
          if (sts_o.need_build) begin
            rstart_q <= index_q;
            rlen_q   <= 8'd1;
          end else begin
            rlen_q <= rlen_inc;
          end
          seen_q  <= 1'b0;
          index_q <= index_q + 16'd1;
        end
      end
      if (load_eod || emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      entry_q     <= {entry_bytes_d_i, entry_bytes_c_i, entry_bytes_b_i, entry_bytes_a_i};
      csum_part_q <= csum_part;
    end
    if (cmd_i.decode) begin
      wcnt_q  <= (sts_o.is_lfn && !first) ? 4'd1 : 4'd0;
      wpos_q  <= '0;
      rp_q    <= '0;
      n_q     <= '0;
      chunk_q <= '0;
    end
    if (cmd_i.lfn_write) begin
      wcnt_q <= wcnt_q + 4'd1;
    end
    if (cmd_i.sfn_write) begin
      if (wcnt_q < 4'd8 && b[{1'b0, wcnt_q}] == fdep_pkg::CharSpace) begin
        wcnt_q <= 4'd8;
      end else begin
        wcnt_q <= wcnt_q + 4'd1;
        wpos_q <= wpos_q + 4'd1;
      end
    end
    if (cmd_i.rd_issue) begin
      cap_q <= rp_q == fdep_pkg::StorePw'(fdep_pkg::StoreDepth);
    end
    if (cmd_i.rd_take && !sts_o.term) begin
      rp_q <= rp_q + fdep_pkg::StorePw'(1);
      if (sts_o.full) begin
        chunk_q <= {56'd0, rdata};
        n_q     <= 4'd1;
      end else begin
        chunk_q[8*lane[2:0] +: 8] <= rdata;
        n_q <= n_q + 4'd1;
      end
    end
    if (load_eod) begin
      name_chunk_o       <= '0;
      chunk_bytes_o      <= '0;
      last_chunk_o       <= 1'b1;
      end_of_directory_o <= 1'b1;
      attributes_o       <= '0;
      file_size_o        <= '0;
      first_cluster_o    <= '0;
      created_stamp_o    <= '0;
      modified_stamp_o   <= '0;
      accessed_date_o    <= '0;
      entry_start_o      <= '0;
      entry_count_o      <= '0;
    end else if (emit) begin
      name_chunk_o       <= chunk_q;
      chunk_bytes_o      <= n_q;
      last_chunk_o       <= sts_o.term;
      end_of_directory_o <= 1'b0;
      attributes_o       <= b[11];
      file_size_o        <= {b[31], b[30], b[29], b[28]};
      first_cluster_o    <= {b[21], b[20], b[27], b[26]};
      created_stamp_o    <= {b[17], b[16], b[15], b[14]};
      modified_stamp_o   <= {b[25], b[24], b[23], b[22]};
      accessed_date_o    <= {b[19], b[18]};
      entry_start_o      <= rstart_q;
      entry_count_o      <= rlen_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
